>>> design/tttr_pkg.sv
// tttr_pkg: sizes, command and result codes, and the slot record type
// for the tick task release table; no dependencies
package tttr_pkg;

	localparam int SLOT_COUNT   = 16;
	localparam int PENDING_BITS = 8;

	// walk counter holds 0 .. SLOT_COUNT-1
	localparam int STEP_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int CMD_W   = 2;
	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 5;
	localparam int TIME_W  = 16;
	localparam int DELAY_W = TIME_W + 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;

	// "no slot" marker on the slot index field
	localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(SLOT_COUNT);

	localparam logic [PENDING_BITS-1:0] PENDING_MAX = '1;

	typedef struct packed {
		logic                    used;
		logic [DELAY_W-1:0]      delay;
		logic [TIME_W-1:0]       period;
		logic [PENDING_BITS-1:0] pending;
	} slot_rec_t;

	localparam slot_rec_t REC_CLEAR = '0;

	// per-step status from the slot unit to the walk control
	typedef struct packed {
		logic run;   // slot is emitted by dispatch
		logic take;  // slot is claimed by add
	} slot_stat_t;

endpackage

>>> design/tttr_cell.sv
// tttr_cell: one storage cell of the slot ring, holds one slot record
// and passes it to its neighbor on each walk step; uses tttr_pkg
module tttr_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  tttr_pkg::slot_rec_t rec_in,
	output tttr_pkg::slot_rec_t rec_q
);
	import tttr_pkg::*;

	// record register, cleared on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= REC_CLEAR;
		end else if (shift) begin
			rec_q <= rec_in;
		end
	end

endmodule

>>> design/tttr_slot_op.sv
// tttr_slot_op: applies the current command to the record at the head
// of the ring and reports run and claim status; uses tttr_pkg
module tttr_slot_op (
	input  logic [tttr_pkg::CMD_W-1:0]  cmd,
	input  logic [tttr_pkg::TIME_W-1:0] period,
	input  logic [tttr_pkg::TIME_W-1:0] start_delay,
	input  logic                        del_hit,
	input  logic                        add_open,
	input  tttr_pkg::slot_rec_t         rec,
	output tttr_pkg::slot_rec_t         rec_next,
	output tttr_pkg::slot_stat_t        stat
);
	import tttr_pkg::*;

	// per-command record update
	always_comb begin
		rec_next = rec;
		stat     = '0;
		unique case (cmd)
			CMD_TICK: begin
				if (rec.used) begin
					if (rec.delay == '0) begin
						if (rec.pending != PENDING_MAX)
							rec_next.pending = rec.pending + 1'b1;
						if (rec.period != '0)
							rec_next.delay = {1'b0, rec.period} - 1'b1;
					end else begin
						rec_next.delay = rec.delay - 1'b1;
					end
				end
			end
			CMD_ADD: begin
				if (add_open && !rec.used) begin
					stat.take        = 1'b1;
					rec_next.used    = 1'b1;
					rec_next.period  = period;
					rec_next.delay   = {1'b0, period} + {1'b0, start_delay};
					rec_next.pending = '0;
				end
			end
			CMD_DELETE: begin
				if (del_hit)
					rec_next = REC_CLEAR;
			end
			default: begin
				// dispatch
				if (rec.pending != '0) begin
					stat.run         = 1'b1;
					rec_next.pending = rec.pending - 1'b1;
					if (rec.period == '0)
						rec_next = REC_CLEAR;
				end
			end
		endcase
	end

endmodule

>>> design/tick_task_release_table.sv
// tick_task_release_table: top level, ring of slot cells walked once
// per command, head slot unit, walk control and result register
// uses tttr_pkg, tttr_cell, tttr_slot_op
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+------------------------------------
//  input   | in_valid  | in_stall  | cmd, period, start_delay, slot
//  output  | out_valid | out_stall | kind, slot_index, ok, last
//
// every command rotates the slot ring once: SLOT_COUNT steps, one slot
// through the head unit per step, one command in work at a time.
// after a beat is taken the input stalls until the walk ends for tick, and for
// add, delete and dispatch until the closing beat is loaded.
// a run step or the closing beat waits while out_stall holds a waiting beat.
// reset clears every slot record at once, no sweep.
module tick_task_release_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tttr_pkg::CMD_W-1:0]    cmd,
	input  logic [tttr_pkg::TIME_W-1:0]   period,
	input  logic [tttr_pkg::TIME_W-1:0]   start_delay,
	input  logic [tttr_pkg::SLOT_W-1:0]   slot,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tttr_pkg::KIND_W-1:0]   kind,
	output logic [tttr_pkg::SLOT_W-1:0]   slot_index,
	output logic                          ok,
	output logic                          last
);
	import tttr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [STEP_W-1:0]     step_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [TIME_W-1:0]     period_q;
	logic [TIME_W-1:0]     delay_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  found_q;
	logic [SLOT_W-1:0]     found_idx_q;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [SLOT_W-1:0]     slot_index_q;
	logic                  ok_q;
	logic                  last_q;

	slot_rec_t             ring [SLOT_COUNT];
	slot_rec_t             head_next;
	slot_stat_t            stat;

	logic                  in_take;
	logic                  out_free;
	logic                  out_load;
	logic                  step_go;
	logic                  step_end;
	logic                  del_in_range;
	logic                  del_hit;
	logic [SLOT_W-1:0]     step_idx;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign step_idx     = SLOT_W'(step_q);
	assign del_in_range = (32'(slot_q) < SLOT_COUNT);
	assign del_hit      = del_in_range && (32'(slot_q) == 32'(step_q));

	// a step waits only when it has a run beat and the result register holds a beat under out_stall
	assign step_go  = (state_q == ST_WALK) && (!stat.run || out_free);
	assign step_end = (32'(step_q) == SLOT_COUNT - 1);

	// result register takes a new beat: run beat in the walk or closing beat
	assign out_load = (step_go && stat.run) || ((state_q == ST_FIN) && out_free);

	// head unit
	tttr_slot_op u_op (
		.cmd         (cmd_q),
		.period      (period_q),
		.start_delay (delay_q),
		.del_hit     (del_hit),
		.add_open    (!found_q),
		.rec         (ring[0]),
		.rec_next    (head_next),
		.stat        (stat)
	);

	// slot ring: cell k takes from cell k+1, the tail takes the head unit output
	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_ring
		if (k == SLOT_COUNT - 1) begin : g_tail
			tttr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (step_go),
				.rec_in (head_next),
				.rec_q  (ring[k])
			);
		end else begin : g_body
			tttr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (step_go),
				.rec_in (ring[k+1]),
				.rec_q  (ring[k])
			);
		end
	end

	// command latch, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q    <= cmd;
			period_q <= period;
			delay_q  <= start_delay;
			slot_q   <= slot;
		end
		if (step_go && stat.take)
			found_idx_q <= step_idx;
	end

	// walk control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_ADD;
			slot_index_q <= '0;
			ok_q         <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_free)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_WALK;
						step_q  <= '0;
						found_q <= 1'b0;
					end
				end
				ST_WALK: begin
					if (step_go) begin
						if (stat.take)
							found_q <= 1'b1;
						if (stat.run) begin
							kind_q       <= KIND_RUN;
							slot_index_q <= step_idx;
							ok_q         <= 1'b1;
							last_q       <= 1'b0;
						end
						if (step_end) begin
							step_q  <= '0;
							state_q <= (cmd_q == CMD_TICK) ? ST_IDLE : ST_FIN;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					// closing beat for add, delete and dispatch
					if (out_free) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
						unique case (cmd_q)
							CMD_ADD: begin
								kind_q       <= KIND_ADD;
								slot_index_q <= found_q ? found_idx_q : NONE_SLOT;
								ok_q         <= found_q;
							end
							CMD_DELETE: begin
								kind_q       <= KIND_DEL;
								slot_index_q <= del_in_range ? slot_q : NONE_SLOT;
								ok_q         <= del_in_range;
							end
							default: begin
								kind_q       <= KIND_IDLE;
								slot_index_q <= NONE_SLOT;
								ok_q         <= 1'b1;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign slot_index = slot_index_q;
	assign ok         = ok_q;
	assign last       = last_q;

	// a taken command blocks the input until its walk is done
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input not blocked after command taken");

	// run beats never close a command
	a_run_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_RUN) |-> !last)
		else $error("run beat marked last");

	// the walk counter rests at zero between commands
	a_step_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (step_q == '0))
		else $error("walk counter not at rest");

	// only a dispatch walk emits run beats
	a_run_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && stat.run) |-> (cmd_q == CMD_DISPATCH))
		else $error("run beat outside dispatch");

endmodule

>>> sim/tttr_checker.sv
// tttr_checker: watches both channels of the tick task release table, keeps
// its own copy of the slot table, predicts every result beat and compares
// depends on tttr_pkg
module tttr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tttr_pkg::CMD_W-1:0]    cmd,
	input  logic [tttr_pkg::TIME_W-1:0]   period,
	input  logic [tttr_pkg::TIME_W-1:0]   start_delay,
	input  logic [tttr_pkg::SLOT_W-1:0]   slot,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tttr_pkg::KIND_W-1:0]   kind,
	input  logic [tttr_pkg::SLOT_W-1:0]   slot_index,
	input  logic                          ok,
	input  logic                          last,
	output int                            fail_count,
	output int                            beats_waiting
);
	import tttr_pkg::*;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot_index;
		logic              ok;
		logic              last;
	} result_beat_t;

	// predicted slot table
	logic                    slot_busy    [SLOT_COUNT];
	logic [DELAY_W-1:0]      countdown    [SLOT_COUNT];
	logic [TIME_W-1:0]       repeat_ticks [SLOT_COUNT];
	logic [PENDING_BITS-1:0] runs_owed    [SLOT_COUNT];

	result_beat_t expected_beats[$];
	result_beat_t want;

	task automatic push_beat(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s, logic good,
		logic fin);
		result_beat_t b;
		b.kind       = k;
		b.slot_index = s;
		b.ok         = good;
		b.last       = fin;
		expected_beats.push_back(b);
	endtask

	task automatic free_slot(int i);
		slot_busy[i]    = 1'b0;
		countdown[i]    = '0;
		repeat_ticks[i] = '0;
		runs_owed[i]    = '0;
	endtask

	// one accepted command against the predicted table
	task automatic release_table_step(logic [CMD_W-1:0] c, logic [TIME_W-1:0] p,
		logic [TIME_W-1:0] d, logic [SLOT_W-1:0] s);
		int free_at;
		free_at = -1;
		case (c)
			CMD_TICK: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_busy[i]) begin
						if (countdown[i] == '0) begin
							if (runs_owed[i] != PENDING_MAX)
								runs_owed[i] = runs_owed[i] + 1'b1;
							if (repeat_ticks[i] != '0)
								countdown[i] = DELAY_W'(repeat_ticks[i] - 1'b1);
						end else begin
							countdown[i] = countdown[i] - 1'b1;
						end
					end
				end
			end
			CMD_ADD: begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (!slot_busy[i] && free_at < 0)
						free_at = i;
				if (free_at < 0) begin
					push_beat(KIND_ADD, NONE_SLOT, 1'b0, 1'b1);
				end else begin
					slot_busy[free_at]    = 1'b1;
					repeat_ticks[free_at] = p;
					countdown[free_at]    = DELAY_W'(p) + DELAY_W'(d);
					runs_owed[free_at]    = '0;
					push_beat(KIND_ADD, SLOT_W'(free_at), 1'b1, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (s >= SLOT_COUNT) begin
					push_beat(KIND_DEL, NONE_SLOT, 1'b0, 1'b1);
				end else begin
					free_slot(s);
					push_beat(KIND_DEL, s, 1'b1, 1'b1);
				end
			end
			default: begin
				// dispatch: one run beat per owed slot, ascending, then idle marker
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (runs_owed[i] != '0) begin
						push_beat(KIND_RUN, SLOT_W'(i), 1'b1, 1'b0);
						runs_owed[i] = runs_owed[i] - 1'b1;
						if (repeat_ticks[i] == '0)
							free_slot(i);
					end
				end
				push_beat(KIND_IDLE, NONE_SLOT, 1'b1, 1'b1);
			end
		endcase
	endtask

	// compare output beats first, then predict from the input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				free_slot(i);
			expected_beats.delete();
			fail_count    = 0;
			beats_waiting = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with none expected: kind %0d slot_index %0d ok %0d last %0d",
						kind, slot_index, ok, last);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						fail_count++;
					end
					if (slot_index !== want.slot_index) begin
						$error("slot_index: expected %0d, actual %0d", want.slot_index,
							slot_index);
						fail_count++;
					end
					if (ok !== want.ok) begin
						$error("ok: expected %0d, actual %0d", want.ok, ok);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				release_table_step(cmd, period, start_delay, slot);
			beats_waiting = expected_beats.size();
		end
	end

endmodule

>>> sim/tick_task_release_table_test.sv
// tick_task_release_table_test: clock, reset, command stimulus and verdict
// depends on tttr_pkg, tick_task_release_table and tttr_checker
module tick_task_release_table_test;
	import tttr_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd;
	logic [TIME_W-1:0]   period;
	logic [TIME_W-1:0]   start_delay;
	logic [SLOT_W-1:0]   slot;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   slot_index;
	logic                ok;
	logic                last;

	logic calm = 1'b0;   // no idling on either side while set
	int   fail_count;
	int   beats_waiting;

	tick_task_release_table DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.period      (period),
		.start_delay (start_delay),
		.slot        (slot),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.slot_index  (slot_index),
		.ok          (ok),
		.last        (last)
	);

	tttr_checker release_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.period        (period),
		.start_delay   (start_delay),
		.slot          (slot),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.slot_index    (slot_index),
		.ok            (ok),
		.last          (last),
		.fail_count    (fail_count),
		.beats_waiting (beats_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stalls now and then
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 7);
	end

	// one command beat, with random idle cycles ahead of it
	task automatic send_beat(logic [CMD_W-1:0] c, logic [TIME_W-1:0] p,
		logic [TIME_W-1:0] d, logic [SLOT_W-1:0] s);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		period      <= p;
		start_delay <= d;
		slot        <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// unused fields carry random noise
	task automatic send_tick();
		send_beat(CMD_TICK, TIME_W'($urandom()), TIME_W'($urandom()), SLOT_W'($urandom()));
	endtask

	task automatic send_dispatch();
		send_beat(CMD_DISPATCH, TIME_W'($urandom()), TIME_W'($urandom()),
			SLOT_W'($urandom()));
	endtask

	task automatic send_add(logic [TIME_W-1:0] p, logic [TIME_W-1:0] d);
		send_beat(CMD_ADD, p, d, SLOT_W'($urandom()));
	endtask

	task automatic send_delete(logic [SLOT_W-1:0] s);
		send_beat(CMD_DELETE, TIME_W'($urandom()), TIME_W'($urandom()), s);
	endtask

	// hold off until every predicted beat has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (beats_waiting != 0)
			@(negedge clk);
	endtask

	// mostly short times so slots release often, sometimes the full range
	function automatic logic [TIME_W-1:0] pick_time();
		int r;
		r = $urandom_range(9);
		if (r < 7)
			return TIME_W'($urandom_range(6));
		else if (r < 9)
			return TIME_W'($urandom_range(40));
		return TIME_W'($urandom());
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		if ($urandom_range(99) < 85)
			return SLOT_W'($urandom_range(SLOT_COUNT - 1));
		return SLOT_W'($urandom_range((1 << SLOT_W) - 1));
	endfunction

	initial begin
		int r;
		in_valid    = 1'b0;
		cmd         = CMD_TICK;
		period      = '0;
		start_delay = '0;
		slot        = '0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: empty table, bad deletes, extreme times, one-shot, full table
		send_dispatch();
		send_tick();
		send_delete('0);
		send_delete(SLOT_W'(SLOT_COUNT));
		send_delete('1);
		send_add('0, '0);
		send_add('1, '1);
		send_add(TIME_W'(1), '0);
		send_add(TIME_W'(2), TIME_W'(1));
		send_tick();
		send_tick();
		send_dispatch();
		for (int n = 0; n < 14; n++)
			send_add(TIME_W'(n % 4), '0);
		send_tick();
		send_dispatch();
		send_delete(SLOT_W'(SLOT_COUNT - 1));
		drain();

		// random command mix, with a quiet stretch and periodic drains
		for (int n = 0; n < 60; n++) begin
			calm = (n >= 20 && n < 45);
			if (n % 20 == 19)
				drain();
			r = $urandom_range(99);
			if (r < 40)
				send_tick();
			else if (r < 60)
				send_add(pick_time(), pick_time());
			else if (r < 75)
				send_delete(pick_slot());
			else
				send_dispatch();
		end
		calm = 1'b0;

		// run of ticks with no dispatch: owed runs pile up
		for (int n = 0; n < SLOT_COUNT; n++)
			send_delete(SLOT_W'(n));
		send_add('0, '0);
		send_add(TIME_W'(1), '0);
		send_add(TIME_W'(3), TIME_W'(2));
		for (int n = 0; n < 12; n++)
			send_tick();
		send_dispatch();
		send_dispatch();

		@(negedge clk) in_valid <= 1'b0;
		while (beats_waiting != 0)
			@(negedge clk);
		repeat (4 * SLOT_COUNT) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
